// ===== hdl/ecoh_pkg.sv =====
// Shared types, constants and helpers for the equatorial to horizontal converter.
package ecoh_pkg;

    typedef logic [31:0]        angle_t;
    typedef logic signed [31:0] q30_t;

    localparam int CORDIC_STEPS = 30;
    localparam int RAD_W        = 61;
    localparam int ROOT_W       = 31;

    localparam q30_t   ONE_Q30       = 32'sh4000_0000;
    localparam angle_t QUARTER_TURN  = 32'h4000_0000;
    localparam angle_t HALF_TURN     = 32'h8000_0000;
    localparam angle_t THREE_QUARTER = 32'hC000_0000;

    // Gain-compensated start value of the rotation CORDIC
    localparam logic signed [33:0] CORDIC_START = 34'sh0_26DD_3B6A;

    // atan(2^-i) in binary angle units, full turn is 2^32
    localparam angle_t ATAN_TAB [CORDIC_STEPS] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001
    };

    // Side data carried through the square root stages
    typedef struct packed {
        logic signed [63:0] az_x;
        logic signed [63:0] az_y;
        q30_t               cz;
        logic               cl_zero;
    } root_side_t;

    // Saturate to the range of +-1.0 in Q1.30
    function automatic q30_t clamp_q30(input logic signed [63:0] v);
        q30_t res;
        if (v > 64'sd1073741824) begin
            res = ONE_Q30;
        end else if (v < -64'sd1073741824) begin
            res = -ONE_Q30;
        end else begin
            res = $signed(v[31:0]);
        end
        return res;
    endfunction

endpackage

// ===== hdl/ecoh_sincos.sv =====
// Pipelined rotation CORDIC giving sine and cosine of a binary angle.
module ecoh_sincos import ecoh_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   in_valid,
    input  angle_t in_angle,
    output logic   out_valid,
    output q30_t   out_cos,
    output q30_t   out_sin
);

    localparam int CW = 34;

    logic                 vld_reg   [0:CORDIC_STEPS];
    logic signed [CW-1:0] x_reg     [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg     [0:CORDIC_STEPS];
    logic signed [CW-1:0] z_reg     [0:CORDIC_STEPS];
    logic                 neg_reg   [0:CORDIC_STEPS];
    logic                 exact_reg [0:CORDIC_STEPS];
    logic [1:0]           quad_reg  [0:CORDIC_STEPS];

    logic signed [31:0]   z32;
    logic signed [CW-1:0] z0_next;
    logic                 neg0_next;
    q30_t                 cx, cy;
    q30_t                 cos_next, sin_next;
    logic                 out_valid_reg;
    q30_t                 out_cos_reg, out_sin_reg;

    // Fold the angle into the right half plane
    always_comb begin
        z32       = $signed(in_angle);
        z0_next   = CW'(z32);
        neg0_next = 1'b0;
        if (z32 > 32'sh4000_0000) begin
            z0_next   = CW'(z32) - 34'sd2147483648;
            neg0_next = 1'b1;
        end else if (z32 < -32'sh4000_0000) begin
            z0_next   = CW'(z32) + 34'sd2147483648;
            neg0_next = 1'b1;
        end
    end

    // Load the first stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            x_reg[0]     <= CORDIC_START;
            y_reg[0]     <= '0;
            z_reg[0]     <= z0_next;
            neg_reg[0]   <= neg0_next;
            exact_reg[0] <= (in_angle[29:0] == 30'd0);
            quad_reg[0]  <= in_angle[31:30];
        end
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        localparam logic signed [CW-1:0] STEP_ANG = $signed({2'b00, ATAN_TAB[i]});
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - STEP_ANG;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + STEP_ANG;
                end
                neg_reg[i+1]   <= neg_reg[i];
                exact_reg[i+1] <= exact_reg[i];
                quad_reg[i+1]  <= quad_reg[i];
            end
        end
    end

    // Clamp, unfold, and substitute exact values on quadrant angles
    always_comb begin
        cx       = clamp_q30(64'(x_reg[CORDIC_STEPS]));
        cy       = clamp_q30(64'(y_reg[CORDIC_STEPS]));
        cos_next = neg_reg[CORDIC_STEPS] ? -cx : cx;
        sin_next = neg_reg[CORDIC_STEPS] ? -cy : cy;
        if (exact_reg[CORDIC_STEPS]) begin
            case (quad_reg[CORDIC_STEPS])
                2'd0: begin
                    cos_next = ONE_Q30;
                    sin_next = '0;
                end
                2'd1: begin
                    cos_next = '0;
                    sin_next = ONE_Q30;
                end
                2'd2: begin
                    cos_next = -ONE_Q30;
                    sin_next = '0;
                end
                default: begin
                    cos_next = '0;
                    sin_next = -ONE_Q30;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[CORDIC_STEPS];
        end
        if (en) begin
            out_cos_reg <= cos_next;
            out_sin_reg <= sin_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cos   = out_cos_reg;
    assign out_sin   = out_sin_reg;

endmodule

// ===== hdl/ecoh_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ecoh_isqrt import ecoh_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int W = RAD_W + 1;

    logic              vld_reg  [0:ROOT_W];
    logic [W-1:0]      v_reg    [0:ROOT_W];
    logic [W-1:0]      r_reg    [0:ROOT_W];
    logic [SIDE_W-1:0] side_reg [0:ROOT_W];

    // Load the radicand
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            v_reg[0]    <= W'(in_rad);
            r_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    // Try one bit pair per stage, from the top down
    for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
        localparam logic [W-1:0] BIT = W'(1) << (2 * (ROOT_W - 1 - k));
        logic [W-1:0] trial;
        assign trial = r_reg[k] + BIT;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            if (en) begin
                if (v_reg[k] >= trial) begin
                    v_reg[k+1] <= v_reg[k] - trial;
                    r_reg[k+1] <= (r_reg[k] >> 1) + BIT;
                end else begin
                    v_reg[k+1] <= v_reg[k];
                    r_reg[k+1] <= r_reg[k] >> 1;
                end
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = r_reg[ROOT_W][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W];

endmodule

// ===== hdl/ecoh_vector.sv =====
// Pipelined atan2: operand normalization followed by a vectoring CORDIC.
module ecoh_vector import ecoh_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic signed [63:0] in_x,
    input  logic signed [63:0] in_y,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output angle_t            out_angle,
    output logic [SIDE_W-1:0] out_side
);

    localparam int VW     = 48;
    localparam int NSTEPS = 6;

    // Normalization stages
    logic               nvld_reg  [0:NSTEPS];
    logic signed [63:0] nx_reg    [0:NSTEPS];
    logic signed [63:0] ny_reg    [0:NSTEPS];
    logic [63:0]        nm_reg    [0:NSTEPS];
    logic               nzero_reg [0:NSTEPS];
    logic [SIDE_W-1:0]  nside_reg [0:NSTEPS];

    // Rotation stages
    logic                 vld_reg  [0:CORDIC_STEPS];
    logic signed [VW-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [VW-1:0] y_reg    [0:CORDIC_STEPS];
    angle_t               z_reg    [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];
    logic [SIDE_W-1:0]    side_reg [0:CORDIC_STEPS];

    logic [63:0] ax, ay;
    logic signed [VW-1:0] x0, y0;

    assign ax = in_x[63] ? 64'(-in_x) : 64'(in_x);
    assign ay = in_y[63] ? 64'(-in_y) : 64'(in_y);

    // Take the larger magnitude
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nvld_reg[0] <= 1'b0;
        end else if (en) begin
            nvld_reg[0] <= in_valid;
        end
        if (en) begin
            nx_reg[0]    <= in_x;
            ny_reg[0]    <= in_y;
            nm_reg[0]    <= (ay > ax) ? ay : ax;
            nzero_reg[0] <= (in_x == 64'sd0) && (in_y == 64'sd0);
            nside_reg[0] <= in_side;
        end
    end

    // Bring the magnitude into [2^40, 2^41), one binary shift size per stage
    for (genvar j = 0; j < NSTEPS; j++) begin : g_norm
        localparam int          SH       = 32 >> j;
        localparam bit          CAN_DOWN = (40 + SH) < 63;
        localparam logic [63:0] HI_LIM   = 64'd1 << (CAN_DOWN ? 40 + SH : 0);
        localparam logic [63:0] LO_LIM   = 64'd1 << (41 - SH);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nvld_reg[j+1] <= 1'b0;
            end else if (en) begin
                nvld_reg[j+1] <= nvld_reg[j];
            end
            if (en) begin
                if (CAN_DOWN && nm_reg[j] >= HI_LIM) begin
                    nx_reg[j+1] <= nx_reg[j] >>> SH;
                    ny_reg[j+1] <= ny_reg[j] >>> SH;
                    nm_reg[j+1] <= nm_reg[j] >> SH;
                end else if (nm_reg[j] < LO_LIM) begin
                    nx_reg[j+1] <= nx_reg[j] <<< SH;
                    ny_reg[j+1] <= ny_reg[j] <<< SH;
                    nm_reg[j+1] <= nm_reg[j] << SH;
                end else begin
                    nx_reg[j+1] <= nx_reg[j];
                    ny_reg[j+1] <= ny_reg[j];
                    nm_reg[j+1] <= nm_reg[j];
                end
                nzero_reg[j+1] <= nzero_reg[j];
                nside_reg[j+1] <= nside_reg[j];
            end
        end
    end

    assign x0 = VW'(nx_reg[NSTEPS]);
    assign y0 = VW'(ny_reg[NSTEPS]);

    // Flip into the right half plane
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= nvld_reg[NSTEPS];
        end
        if (en) begin
            if (x0 < 0) begin
                x_reg[0] <= -x0;
                y_reg[0] <= -y0;
                z_reg[0] <= HALF_TURN;
            end else begin
                x_reg[0] <= x0;
                y_reg[0] <= y0;
                z_reg[0] <= '0;
            end
            zero_reg[0] <= nzero_reg[NSTEPS];
            side_reg[0] <= nside_reg[NSTEPS];
        end
    end

    // Drive y toward zero and accumulate the angle
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS];
    assign out_angle = zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];

endmodule

// ===== hdl/equatorial_to_horizontal_unit.sv =====
// Top level of the equatorial to horizontal coordinate converter.
//
// Input words on s_* carry right ascension, declination and local sidereal
// time; each produces exactly one output word on m_* with azimuth and
// elevation, plus a tuser flag set when the azimuth is undefined (pole,
// zenith or nadir) and forced to zero. The site latitude is loaded through
// cfg_wr_en/cfg_wr_data; the user must load it only while no conversion is
// in flight, as the block itself does not enforce this. The datapath is a
// fixed pipeline: input register, three parallel sine and cosine CORDICs,
// five multiply/add stages, a 32-stage square root, and two parallel atan2
// units, then a two-word output buffer. Throughput is one word per cycle
// while the output buffer is not full; each CORDIC iteration has its own stage.
// s_tready comes from a register: it drops only when the output buffer is
// full, which freezes the whole pipeline without losing or repeating words.
// Reset (aresetn low, synchronous) clears all valid bits, empties the output
// buffer and sets the latitude to zero.
module equatorial_to_horizontal_unit import ecoh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // site_latitude
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,       // right_ascension, declination, sidereal_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // azimuth_angle, elevation_angle
    output logic        m_tuser        // azimuth_undefined
);

    localparam int SIDE_R = $bits(root_side_t);

    logic   en;
    angle_t site_latitude_reg;

    // Latitude register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            site_latitude_reg <= '0;
        end else if (cfg_wr_en) begin
            site_latitude_reg <= cfg_wr_data;
        end
    end

    // Input stage: form the hour angle
    logic   in_vld_reg;
    angle_t lat_in_reg, dec_in_reg, ha_in_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
        if (en) begin
            lat_in_reg <= site_latitude_reg;
            dec_in_reg <= s_tdata[63:32];
            ha_in_reg  <= s_tdata[95:64] - s_tdata[31:0];
        end
    end

    // Sines and cosines of latitude, declination and hour angle
    logic sc_vld;
    q30_t cl, sl, cd, sd, ch, sh;

    ecoh_sincos u_sc_lat (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_vld_reg),
        .in_angle(lat_in_reg), .out_valid(sc_vld), .out_cos(cl), .out_sin(sl)
    );
    ecoh_sincos u_sc_dec (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_vld_reg),
        .in_angle(dec_in_reg), .out_valid(), .out_cos(cd), .out_sin(sd)
    );
    ecoh_sincos u_sc_ha (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(in_vld_reg),
        .in_angle(ha_in_reg), .out_valid(), .out_cos(ch), .out_sin(sh)
    );

    // Stage A: first products
    logic               a_vld_reg;
    logic signed [63:0] a_ss_reg, a_cc_reg, a_cs_reg;
    q30_t               a_sl_reg, a_sd_reg, a_ch_reg, a_cl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= sc_vld;
        end
        if (en) begin
            a_ss_reg <= sl * sd;
            a_cc_reg <= cl * cd;
            a_cs_reg <= cd * sh;
            a_sl_reg <= sl;
            a_sd_reg <= sd;
            a_ch_reg <= ch;
            a_cl_reg <= cl;
        end
    end

    // Stage B: second products
    logic               b_vld_reg;
    logic signed [63:0] b_ss_reg, b_p3_reg, b_y_reg;
    q30_t               b_sl_reg, b_sd_reg;
    logic               b_cl_neg_reg, b_cl_zero_reg;
    q30_t               cc_q, ycs_q, abs_cl;
    logic signed [63:0] neg_cs;

    always_comb begin
        cc_q   = 32'(a_cc_reg >>> 30);
        neg_cs = -a_cs_reg;
        ycs_q  = 32'(neg_cs >>> 30);
        abs_cl = a_cl_reg[31] ? -a_cl_reg : a_cl_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
        if (en) begin
            b_ss_reg      <= a_ss_reg;
            b_p3_reg      <= cc_q * a_ch_reg;
            b_y_reg       <= ycs_q * abs_cl;
            b_sl_reg      <= a_sl_reg;
            b_sd_reg      <= a_sd_reg;
            b_cl_neg_reg  <= a_cl_reg[31];
            b_cl_zero_reg <= (a_cl_reg == 32'sd0);
        end
    end

    // Stage C: zenith-angle cosine
    logic               c_vld_reg;
    q30_t               c_cz_reg, c_sl_reg, c_sd_reg;
    logic signed [63:0] c_y_reg;
    logic               c_cl_neg_reg, c_cl_zero_reg;
    logic signed [63:0] cz_sum;

    assign cz_sum = b_ss_reg + b_p3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
        if (en) begin
            c_cz_reg      <= clamp_q30(cz_sum >>> 30);
            c_sl_reg      <= b_sl_reg;
            c_sd_reg      <= b_sd_reg;
            c_y_reg       <= b_y_reg;
            c_cl_neg_reg  <= b_cl_neg_reg;
            c_cl_zero_reg <= b_cl_zero_reg;
        end
    end

    // Stage D: products with the zenith-angle cosine
    logic               d_vld_reg;
    logic signed [63:0] d_r_reg, d_cc_reg, d_y_reg;
    q30_t               d_cz_reg, d_sd_reg;
    logic               d_cl_neg_reg, d_cl_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= c_vld_reg;
        end
        if (en) begin
            d_r_reg       <= c_sl_reg * c_cz_reg;
            d_cc_reg      <= c_cz_reg * c_cz_reg;
            d_y_reg       <= c_y_reg;
            d_cz_reg      <= c_cz_reg;
            d_sd_reg      <= c_sd_reg;
            d_cl_neg_reg  <= c_cl_neg_reg;
            d_cl_zero_reg <= c_cl_zero_reg;
        end
    end

    // Stage E: azimuth cosine term and the radicand
    logic               e_vld_reg;
    logic [RAD_W-1:0]   e_rad_reg;
    root_side_t         e_side_reg;
    logic signed [63:0] ax_raw, rad_full;

    always_comb begin
        ax_raw   = (64'(d_sd_reg) <<< 30) - d_r_reg;
        rad_full = 64'sh1000_0000_0000_0000 - d_cc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg <= d_vld_reg;
        end
        if (en) begin
            e_rad_reg          <= rad_full[63] ? '0 : rad_full[RAD_W-1:0];
            e_side_reg.az_x    <= d_cl_neg_reg ? -ax_raw : ax_raw;
            e_side_reg.az_y    <= d_y_reg;
            e_side_reg.cz      <= d_cz_reg;
            e_side_reg.cl_zero <= d_cl_zero_reg;
        end
    end

    // Zenith-angle sine
    logic              rt_vld;
    logic [ROOT_W-1:0] sz;
    root_side_t        rt_side;

    ecoh_isqrt #(.SIDE_W(SIDE_R)) u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(e_vld_reg),
        .in_rad(e_rad_reg), .in_side(e_side_reg),
        .out_valid(rt_vld), .out_root(sz), .out_side(rt_side)
    );

    // Elevation and azimuth angles
    logic [2:0] el_side_in, el_side;
    logic [1:0] az_side_in, az_side;
    logic       el_vld;
    angle_t     el_ang, az_ang;

    assign el_side_in = {sz == '0, rt_side.cz[31], rt_side.cl_zero};
    assign az_side_in = {rt_side.az_x == 64'sd0, rt_side.az_y > 64'sd0};

    ecoh_vector #(.SIDE_W(3)) u_vec_el (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rt_vld),
        .in_x(64'(sz)), .in_y(64'(rt_side.cz)), .in_side(el_side_in),
        .out_valid(el_vld), .out_angle(el_ang), .out_side(el_side)
    );
    ecoh_vector #(.SIDE_W(2)) u_vec_az (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(rt_vld),
        .in_x(rt_side.az_x), .in_y(rt_side.az_y), .in_side(az_side_in),
        .out_valid(), .out_angle(az_ang), .out_side(az_side)
    );

    // Apply zenith, pole and meridian special cases
    angle_t fin_az, fin_el;
    logic   fin_flag;

    always_comb begin
        if (el_side[2]) begin
            fin_el = el_side[1] ? THREE_QUARTER : QUARTER_TURN;
        end else begin
            fin_el = el_ang;
        end
        if (!el_side[0] && !el_side[2]) begin
            fin_flag = 1'b0;
            if (az_side[1]) begin
                fin_az = az_side[0] ? QUARTER_TURN : THREE_QUARTER;
            end else begin
                fin_az = az_ang;
            end
        end else begin
            fin_flag = 1'b1;
            fin_az   = '0;
        end
    end

    // Two-word output buffer; hold the pipeline when full
    logic [1:0]  cnt_reg;
    logic [64:0] head_reg, tail_reg;
    logic        push, pop;
    logic [64:0] fin_word;

    assign en       = (cnt_reg != 2'd2);
    assign push     = el_vld && en;
    assign pop      = m_tvalid && m_tready;
    assign fin_word = {fin_flag, fin_el, fin_az};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            case (cnt_reg)
                2'd0: begin
                    if (push) begin
                        cnt_reg <= 2'd1;
                    end
                end
                2'd1: begin
                    if (push && !pop) begin
                        cnt_reg <= 2'd2;
                    end else if (!push && pop) begin
                        cnt_reg <= 2'd0;
                    end
                end
                default: begin
                    if (pop) begin
                        cnt_reg <= 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_reg == 2'd2) begin
            if (pop) begin
                head_reg <= tail_reg;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0 || pop) begin
                head_reg <= fin_word;
            end else begin
                tail_reg <= fin_word;
            end
        end
    end

    assign s_tready = en;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = head_reg[63:0];
    assign m_tuser  = head_reg[64];

endmodule

// ===== dv/tb_equatorial_to_horizontal_unit.sv =====
// Self-checking testbench for the equatorial to horizontal coordinate converter.
module tb_equatorial_to_horizontal_unit;
    import ecoh_pkg::*;

    typedef struct {
        logic [31:0] az;
        logic [31:0] el;
        logic        undef;
    } horiz_t;

    typedef struct {
        logic [31:0] ra;
        logic [31:0] dec;
        logic [31:0] lst;
        bit          pinned;
        horiz_t      res;
    } pointing_row_t;

    localparam longint UNIT_Q30 = 64'sd1 << 30;
    localparam longint QTR = 64'sd1 << 30;
    localparam int     DRAIN_CYCLES = 130;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // right_ascension, declination, sidereal_time
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // azimuth_angle, elevation_angle
    logic        m_tuser;   // azimuth_undefined

    logic        rx_ready;
    logic        rx_hold;
    logic [31:0] latitude;
    longint      atan_units [CORDIC_STEPS];
    horiz_t      pending_q[$];
    int          errors;
    int          words_sent;
    pointing_row_t rows [16];

    equatorial_to_horizontal_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    assign m_tready = rx_ready && !rx_hold;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Build the arctangent table from its series expansion
    initial begin
        longint unsigned sum;
        longint unsigned term;
        logic [127:0]    prod;
        int              e;
        atan_units[0] = 64'sd1 << 29;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            sum = 0;
            for (int k = 0; ; k++) begin
                e = 62 - (2 * k + 1) * i;
                if (e < 0) break;
                term = (64'd1 << e) / longint'(2 * k + 1);
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            prod = {64'd0, sum} * {64'd0, 64'h28BE60DB9391054A};
            atan_units[i] = longint'((prod[127:64] + (64'd1 << 29)) >> 30);
        end
    end

    function automatic longint sat_unit(longint v);
        return v > UNIT_Q30 ? UNIT_Q30 : (v < -UNIT_Q30 ? -UNIT_Q30 : v);
    endfunction

    // Rotation CORDIC: cosine and sine of a binary angle in Q1.30
    function automatic void rotate_angle(logic [31:0] a, output longint c,
                                         output longint s);
        longint x, y, z, dx, dy;
        bit     flip;
        x = 64'sh26DD3B6A;
        y = 0;
        flip = 0;
        if (a[29:0] == 0) begin
            c = a[31:30] == 2'd0 ? UNIT_Q30 : (a[31:30] == 2'd2 ? -UNIT_Q30 : 0);
            s = a[31:30] == 2'd1 ? UNIT_Q30 : (a[31:30] == 2'd3 ? -UNIT_Q30 : 0);
            return;
        end
        z = longint'($signed(a));
        if (z > QTR) begin
            z = z - 2 * QTR;
            flip = 1;
        end else if (z < -QTR) begin
            z = z + 2 * QTR;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_units[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_units[i];
            end
        end
        x = sat_unit(x);
        y = sat_unit(y);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Vectoring CORDIC: atan2(y, x) as a binary angle
    function automatic logic [31:0] vector_angle(longint x, longint y);
        longint unsigned z, m, ay;
        longint          dx, dy;
        if (x == 0 && y == 0) return 32'd0;
        m = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        if (ay > m) m = ay;
        z = 0;
        while (m >= (64'd1 << 41)) begin
            x = x >>> 1; y = y >>> 1; m = m >> 1;
        end
        while (m < (64'd1 << 40)) begin
            x = x * 2; y = y * 2; m = m << 1;
        end
        if (x < 0) begin
            x = -x; y = -y; z = 64'd1 << 31;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + atan_units[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_units[i];
            end
        end
        return z[31:0];
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Convert one pointing word to azimuth and elevation
    function automatic horiz_t convert_pointing(logic [31:0] lat, logic [31:0] ra,
                                                logic [31:0] dec, logic [31:0] lst);
        longint cl, sl, cd, sd, ch, sh, cz, sz, rad, ax, ay;
        logic [31:0] hour;
        horiz_t r;
        hour = lst - ra;
        rotate_angle(lat, cl, sl);
        rotate_angle(dec, cd, sd);
        rotate_angle(hour, ch, sh);
        cz = sat_unit((sl * sd + ((cl * cd) >>> 30) * ch) >>> 30);
        rad = UNIT_Q30 * UNIT_Q30 - cz * cz;
        sz = rad <= 0 ? 0 : longint'(root_floor(rad));
        if (sz != 0) r.el = vector_angle(sz, cz);
        else r.el = cz >= 0 ? QUARTER_TURN : THREE_QUARTER;
        r.az = 32'd0;
        r.undef = 1'b1;
        if (cl != 0 && sz != 0) begin
            ay = ((-(cd * sh)) >>> 30) * (cl < 0 ? -cl : cl);
            ax = sd * UNIT_Q30 - sl * cz;
            if (cl < 0) ax = -ax;
            if (ax == 0) r.az = ay > 0 ? QUARTER_TURN : THREE_QUARTER;
            else r.az = vector_angle(ax, ay);
            r.undef = 1'b0;
        end
        return r;
    endfunction

    // Offer one word after a random gap, queue its expectation on acceptance
    task automatic send_word(pointing_row_t row);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {row.lst, row.dec, row.ra};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_q.push_back(row.pinned ? row.res
                            : convert_pointing(latitude, row.ra, row.dec, row.lst));
        words_sent++;
    endtask

    // Drain the pipeline, then load a new latitude
    task automatic load_latitude(logic [31:0] lat);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lat;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        latitude = lat;
    endtask

    task automatic send_random(int count);
        pointing_row_t row;
        for (int n = 0; n < count; n++) begin
            row.pinned = 0;
            row.ra = $urandom;
            row.lst = $urandom;
            case ($urandom_range(0, 5))
                0: row.dec = $urandom;
                1: row.dec = {2'($urandom_range(0, 3)), 30'd0};
                2: begin
                    row.dec = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
                    row.lst = row.ra + {2'($urandom_range(0, 3)), 30'd0};
                end
                default: row.dec = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
            endcase
            send_word(row);
        end
    endtask

    // Result side: random stall before each word
    initial begin
        int w;
        rx_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            w = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                @(negedge aclk);
                rx_ready <= 1'b0;
                repeat (w - 1) @(negedge aclk);
            end
            @(negedge aclk);
            rx_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // Hold off the result side for a long stretch to back up the pipeline
    initial begin
        rx_hold = 1'b0;
        while (words_sent < 200) @(negedge aclk);
        rx_hold <= 1'b1;
        repeat (400) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        horiz_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word az=%h el=%h undef=%b", $time,
                         m_tdata[31:0], m_tdata[63:32], m_tuser);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (m_tdata[31:0] !== want.az) begin
                    $display("%0t: azimuth expected %h actual %h", $time,
                             want.az, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.el) begin
                    $display("%0t: elevation expected %h actual %h", $time,
                             want.el, m_tdata[63:32]);
                    errors++;
                end
                if (m_tuser !== want.undef) begin
                    $display("%0t: undefined flag expected %b actual %b", $time,
                             want.undef, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        horiz_t none;
        none = '{32'd0, 32'd0, 1'b0};
        errors = 0;
        words_sent = 0;
        latitude = 32'd0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 32'd0;
        s_tvalid = 1'b0;
        s_tdata = 96'd0;
        // zenith and nadir at reset latitude, then extremes and meridian ties
        rows[0] = '{32'd0, 32'd0, 32'd0, 1, '{32'd0, QUARTER_TURN, 1'b1}};
        rows[1] = '{32'd0, 32'd0, HALF_TURN, 1, '{32'd0, THREE_QUARTER, 1'b1}};
        rows[2] = '{32'd0, 32'h4000_0000, 32'd0, 0, none};
        rows[3] = '{32'd0, 32'hC000_0000, 32'd0, 0, none};
        rows[4] = '{32'd0, 32'h8000_0000, 32'd0, 0, none};
        rows[5] = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 0, none};
        rows[6] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none};
        rows[7] = '{32'd0, 32'd0, QUARTER_TURN, 0, none};
        rows[8] = '{32'd0, 32'd0, THREE_QUARTER, 0, none};
        rows[9] = '{32'h1234_5678, 32'd0, 32'h5234_5678, 0, none};
        rows[10] = '{32'h8000_0000, 32'h2000_0000, 32'h8000_0000, 0, none};
        rows[11] = '{32'd0, 32'hE000_0000, 32'h0000_0001, 0, none};
        rows[12] = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 0, none};
        rows[13] = '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 0, none};
        rows[14] = '{32'h0000_0001, 32'h3FFF_FFFF, 32'hFFFF_FFFF, 0, none};
        rows[15] = '{32'h7FFF_FFFF, 32'hC000_0001, 32'h8000_0000, 0, none};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) send_word(rows[i]);
        send_random(50);
        // sweep latitude over pole, equator, out-of-range and random settings
        load_latitude(32'h4000_0000);
        send_word(rows[2]);
        send_random(60);
        load_latitude(32'hC000_0000);
        send_random(60);
        load_latitude(32'h8000_0000);
        send_random(40);
        load_latitude(32'hFFFF_FFFF);
        send_random(40);
        load_latitude(32'h2AAA_AAAB);
        send_random(80);
        load_latitude($urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
        send_random(80);
        load_latitude($urandom);
        send_random(30);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
